// ===== sv/akf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// akf_pkg
// Shared constants and a saturation helper for the angle Kalman filter.
// ----------------------------------------------------------------------------
package akf_pkg;

  localparam int RegW = 31;
  localparam int InW  = 25;
  localparam int DtW  = 16;
  localparam int StW  = 32;

  localparam logic [RegW-1:0] AngleNoiseRst   = 31'd16777;
  localparam logic [RegW-1:0] BiasNoiseRst    = 31'd50332;
  localparam logic [RegW-1:0] MeasureNoiseRst = 31'd503316;

  // register indexes
  localparam logic [1:0] RegAngleNoise   = 2'd0;
  localparam logic [1:0] RegBiasNoise    = 2'd1;
  localparam logic [1:0] RegMeasureNoise = 2'd2;

  localparam logic FuncUpdate = 1'b0;
  localparam logic FuncLoad   = 1'b1;

  // multiplier operand and product widths
  localparam int MulW = 33;
  localparam int ProdW = 66;

  // saturate a wide signed value to 32 bits
  function automatic logic signed [StW-1:0] sat32(input logic signed [ProdW-1:0] v);
    logic signed [StW-1:0] r;
    if (v > 66'sd2147483647) r = 32'sh7fffffff;
    else if (v < -66'sd2147483648) r = 32'sh80000000;
    else r = v[StW-1:0];
    return r;
  endfunction

endpackage

// ===== sv/angle_kalman_filter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// angle_kalman_filter_top
// Two-state angle/bias Kalman filter, one item at a time.
//
// Input beat (s_axis): tuser = func, tdata = measured_angle[24:0],
// gyro_rate[49:25], step_time[65:50], zero padded to 72 bits.
// Output beat (m_axis): tdata = filtered_angle[31:0], rate_bias[63:32].
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; indexes
// beyond the register list are ignored. Write only while idle.
// A load item is valid in the cycle after its beat. An update runs ten
// products and two gain divides in sequence: each product is a set-up step,
// a shift-add multiplier taking one bit a cycle over 33 bits and a final
// step; each divide is a set-up step, a restoring divider over 57 quotient
// bits and a final step. A gain whose P00 + R is not positive is set to
// zero with no divide. A closing step then hands the result to the output.
// One item is in work at a time; s_axis_tready is low while busy.
// Reset clears state estimates, covariance and restores register defaults.
// If the receiver stalls, the result waits in the output register and the
// next item is not taken until it is delivered.
// ----------------------------------------------------------------------------
module angle_kalman_filter_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // measured_angle, gyro_rate, step_time
  input  logic        s_axis_tuser,  // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // filtered_angle, rate_bias
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data
);

  localparam int PW = akf_pkg::ProdW;
  localparam int MW = akf_pkg::MulW;

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_MUL  = 8'b00000010,
    S_STEP = 8'b00000100,
    S_DIV  = 8'b00001000,
    S_OUT  = 8'b00010000
  } state_t;

  state_t state;
  logic [4:0] op;          // micro-step index
  logic [30:0] angle_noise, bias_noise, measure_noise;
  logic signed [31:0] angle_est, bias_est, cov_aa, cov_ab, cov_ba, cov_bb;
  logic signed [24:0] meas;
  logic signed [31:0] rate, y, k0, k1, p00t, p01t, dtp11;
  logic [15:0] dt;

  // serial multiplier: signed a * b, one multiplier bit per cycle
  logic signed [PW-1:0] acc, mcand;
  logic [MW-1:0] mplier;
  logic [5:0] mcnt;
  logic signed [PW-1:0] prod;

  // restoring divider for |p|<<24 / s
  logic [56:0] dquo;
  logic [57:0] drem;
  logic [31:0] dden;
  logic [5:0] dcnt;
  logic dneg;
  logic [57:0] dtrial;
  logic signed [31:0] dsat;

  logic signed [PW-1:0] r16, r24;
  assign prod = acc;
  assign r16 = (prod + 66'sd32768) >>> 16;
  assign r24 = (prod + 66'sd8388608) >>> 24;

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata = {bias_est, angle_est};

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      angle_noise <= akf_pkg::AngleNoiseRst;
      bias_noise <= akf_pkg::BiasNoiseRst;
      measure_noise <= akf_pkg::MeasureNoiseRst;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        akf_pkg::RegAngleNoise:   angle_noise <= cfg_data;
        akf_pkg::RegBiasNoise:    bias_noise <= cfg_data;
        akf_pkg::RegMeasureNoise: measure_noise <= cfg_data;
        default: ;
      endcase
    end
  end

  logic signed [PW-1:0] sx;  // innovation variance
  assign sx = PW'(cov_aa) + PW'(signed'({1'b0, measure_noise}));

  // sign-extend a 32-bit value to the multiplier operand width
  function automatic logic [MW-1:0] ext(input logic signed [31:0] v);
    return {v[31], v};
  endfunction

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op <= '0;
      angle_est <= '0; bias_est <= '0;
      cov_aa <= '0; cov_ab <= '0; cov_ba <= '0; cov_bb <= '0;
      mcnt <= '0; dcnt <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            meas <= signed'(s_axis_tdata[24:0]);
            dt <= s_axis_tdata[65:50];
            if (s_axis_tuser == akf_pkg::FuncLoad) begin
              angle_est <= 32'(signed'(s_axis_tdata[24:0]));
              state <= S_OUT;
            end else begin
              rate <= akf_pkg::sat32(PW'(signed'(s_axis_tdata[49:25])) - PW'(bias_est));
              op <= 5'd0;
              state <= S_STEP;
            end
          end
        end
        // set up next multiply / divide from the micro-step
        S_STEP: begin
          acc <= '0; mcnt <= '0;
          state <= S_MUL;
          case (op)
            5'd0: begin mcand <= PW'(rate); mplier <= MW'(dt); end
            5'd1: begin mcand <= PW'(cov_bb); mplier <= MW'(dt); end
            5'd2: begin
              mcand <= PW'(dtp11) - PW'(cov_ab) - PW'(cov_ba)
                       + PW'(signed'({1'b0, angle_noise}));
              mplier <= MW'(dt);
            end
            5'd3: begin mcand <= PW'(signed'({1'b0, bias_noise})); mplier <= MW'(dt); end
            5'd4, 5'd5: begin
              // gain divide
              state <= S_DIV;
              if (sx <= 0) begin
                if (op == 5'd4) k0 <= '0; else k1 <= '0;
                op <= op + 5'd1;
                state <= S_STEP;
              end else begin
                dneg <= (op == 5'd4) ? cov_aa[31] : cov_ba[31];
                dquo <= 57'({(op == 5'd4) ? (cov_aa[31] ? -cov_aa : cov_aa)
                                          : (cov_ba[31] ? -cov_ba : cov_ba), 24'd0});
                drem <= '0;
                dden <= sx[31:0];
                dcnt <= '0;
              end
            end
            5'd6: begin mcand <= PW'(k0); mplier <= ext(y); end
            5'd7: begin mcand <= PW'(k1); mplier <= ext(y); end
            5'd8: begin mcand <= PW'(k0); mplier <= ext(p00t); end
            5'd9: begin mcand <= PW'(k0); mplier <= ext(p01t); end
            5'd10: begin mcand <= PW'(k1); mplier <= ext(p00t); end
            5'd11: begin mcand <= PW'(k1); mplier <= ext(p01t); end
            default: state <= S_OUT;
          endcase
        end
        // one multiplier bit a cycle; top bit has negative weight
        S_MUL: begin
          if (mplier[0]) begin
            if (mcnt == 6'(MW-1)) acc <= acc - mcand;
            else acc <= acc + mcand;
          end
          mcand <= mcand <<< 1;
          mplier <= mplier >> 1;
          mcnt <= mcnt + 6'd1;
          if (mcnt == 6'(MW-1)) state <= S_MUL;
          if (mcnt == 6'(MW)) begin
            state <= S_STEP;
            op <= op + 5'd1;
            case (op)
              5'd0: angle_est <= akf_pkg::sat32(PW'(angle_est) + r16);
              5'd1: dtp11 <= r16[31:0];
              // off-diagonal terms move only once P00 has used their old values
              5'd2: begin
                cov_aa <= akf_pkg::sat32(PW'(cov_aa) + r16);
                cov_ab <= akf_pkg::sat32(PW'(cov_ab) - PW'(dtp11));
                cov_ba <= akf_pkg::sat32(PW'(cov_ba) - PW'(dtp11));
              end
              5'd3: begin
                cov_bb <= akf_pkg::sat32(PW'(cov_bb) + r16);
                y <= akf_pkg::sat32(PW'(meas) - PW'(angle_est));
              end
              5'd6: angle_est <= akf_pkg::sat32(PW'(angle_est) + r24);
              5'd7: begin
                bias_est <= akf_pkg::sat32(PW'(bias_est) + r24);
                p00t <= cov_aa; p01t <= cov_ab;
              end
              5'd8: cov_aa <= akf_pkg::sat32(PW'(cov_aa) - r24);
              5'd9: cov_ab <= akf_pkg::sat32(PW'(cov_ab) - r24);
              5'd10: cov_ba <= akf_pkg::sat32(PW'(cov_ba) - r24);
              5'd11: cov_bb <= akf_pkg::sat32(PW'(cov_bb) - r24);
              default: ;
            endcase
          end
        end
        // restoring division, one quotient bit a cycle
        S_DIV: begin
          if (dcnt == 6'd57) begin
            if (op == 5'd4) k0 <= dsat; else k1 <= dsat;
            op <= op + 5'd1;
            state <= S_STEP;
          end else begin
            if (dtrial[57] == 1'b0) begin
              drem <= dtrial;
              dquo <= {dquo[55:0], 1'b1};
            end else begin
              drem <= {drem[56:0], dquo[56]};
              dquo <= {dquo[55:0], 1'b0};
            end
            dcnt <= dcnt + 6'd1;
          end
        end
        S_OUT: if (m_axis_tready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign dtrial = {drem[56:0], dquo[56]} - {26'd0, dden};
  always_comb begin
    if (dneg) dsat = (dquo > 57'd2147483648) ? 32'sh80000000 : 32'(-dquo);
    else dsat = (dquo > 57'd2147483647) ? 32'sh7fffffff : dquo[31:0];
  end

  // checks
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input taken with result pending");
  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the two-state angle Kalman filter. Items are driven
// on the input stream and each output beat is checked against a bit-true
// fixed-point filter in the bench, or against the table on typed rows. A
// directed table comes first, then random updates and loads under several
// noise settings and idle patterns, including one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [1:0] RegUnused = 2'd3;  // beyond the register list
  localparam int HoldCycles = 600;
  localparam int WatchLimit = 20000;
  localparam int DrainCycles = 200;

  typedef struct {
    logic        func;
    logic [24:0] meas;
    logic [24:0] gyro;
    logic [15:0] dt;
    bit          typed;
    logic [31:0] t_angle;
    logic [31:0] t_bias;
  } row_t;

  typedef struct {
    logic [31:0] angle;
    logic [31:0] bias;
  } est_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [30:0] cfg_data = '0;

  angle_kalman_filter_top uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // filter copy held by the bench
  longint q_angle, b_noise, m_noise;
  longint f_angle, f_bias, p_aa, p_ab, p_ba, p_bb;
  est_t   est_q[$];
  int     errors = 0;
  int     src_idle = 0, snk_idle = 0, hold_cnt = 0;

  function automatic longint sat(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // rounding right shift, ties toward plus infinity
  function automatic longint rshr(input longint x, input int n);
    longint v;
    v = x + (64'sd1 <<< (n - 1));
    return v >>> n;
  endfunction

  function automatic longint kgain(input longint p, input longint s);
    if (s <= 0) return 0;
    return sat((p * 64'sd16777216) / s);
  endfunction

  function automatic est_t filter_step(input logic func, input logic [24:0] meas_r,
                                       input logic [24:0] gyro_r, input logic [15:0] dt_r);
    longint meas, gyro, dt, rate, dp, inner, s, k0, k1, y, p00, p01;
    est_t e;
    meas = longint'(signed'(meas_r));
    gyro = longint'(signed'(gyro_r));
    dt = longint'(dt_r);
    if (func == akf_pkg::FuncLoad) begin
      f_angle = sat(meas);
    end else begin
      rate = sat(gyro - f_bias);
      f_angle = sat(f_angle + rshr(dt * rate, 16));
      dp = rshr(dt * p_bb, 16);
      inner = dp - p_ab - p_ba + q_angle;
      p_aa = sat(p_aa + rshr(dt * inner, 16));
      p_ab = sat(p_ab - dp);
      p_ba = sat(p_ba - dp);
      p_bb = sat(p_bb + rshr(b_noise * dt, 16));
      s = p_aa + m_noise;
      k0 = kgain(p_aa, s);
      k1 = kgain(p_ba, s);
      y = sat(meas - f_angle);
      f_angle = sat(f_angle + rshr(k0 * y, 24));
      f_bias = sat(f_bias + rshr(k1 * y, 24));
      p00 = p_aa;
      p01 = p_ab;
      p_aa = sat(p_aa - rshr(k0 * p00, 24));
      p_ab = sat(p_ab - rshr(k0 * p01, 24));
      p_ba = sat(p_ba - rshr(k1 * p00, 24));
      p_bb = sat(p_bb - rshr(k1 * p01, 24));
    end
    e.angle = f_angle[31:0];
    e.bias = f_bias[31:0];
    return e;
  endfunction

  // push one item, predict on acceptance
  task automatic send_item(input row_t r);
    est_t e;
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = r.func;
    s_axis_tdata = {6'b0, r.dt, r.gyro, r.meas};
    do @(posedge clk); while (!s_axis_tready);
    e = filter_step(r.func, r.meas, r.gyro, r.dt);
    if (r.typed) begin
      e.angle = r.t_angle;
      e.bias = r.t_bias;
    end
    est_q.push_back(e);
    @(negedge clk);
  endtask

  // register write, only once the filter has gone quiet
  task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
    s_axis_tvalid = 1'b0;
    wait (est_q.size() == 0);
    repeat (DrainCycles) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      akf_pkg::RegAngleNoise:   q_angle = longint'(val);
      akf_pkg::RegBiasNoise:    b_noise = longint'(val);
      akf_pkg::RegMeasureNoise: m_noise = longint'(val);
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic row_t rand_row();
    row_t r;
    int   pick;
    r.typed = 0;
    r.t_angle = '0;
    r.t_bias = '0;
    pick = $urandom_range(99);
    r.func = (pick < 10) ? akf_pkg::FuncLoad : akf_pkg::FuncUpdate;
    if (pick >= 92) begin
      // raw field noise, all bits free
      r.meas = 25'($urandom);
      r.gyro = 25'($urandom);
      r.dt = 16'($urandom);
    end else begin
      r.meas = 25'($urandom_range(23592960) - 11796480);
      r.gyro = 25'($urandom_range(32800000) - 16400000);
      r.dt = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(1300));
    end
    return r;
  endfunction

  // output side: random stalls and the long hold-off
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      m_axis_tready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_idle);
    end
  end

  // result check against oldest expectation
  always @(posedge clk) begin
    est_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (est_q.size() == 0) begin
        $display("%0t: unexpected beat %h", $time, m_axis_tdata);
        errors++;
      end else begin
        e = est_q.pop_front();
        if (m_axis_tdata[31:0] !== e.angle) begin
          $display("%0t: filtered_angle exp %h got %h", $time, e.angle, m_axis_tdata[31:0]);
          errors++;
        end
        if (m_axis_tdata[63:32] !== e.bias) begin
          $display("%0t: rate_bias exp %h got %h", $time, e.bias, m_axis_tdata[63:32]);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any beat
  int quiet = 0;
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready) || rst)
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= WatchLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  row_t dir_rows[10];

  initial begin
    dir_rows[0] = '{akf_pkg::FuncUpdate, 25'd11796480, 25'h0FFFFFF, 16'd0, 1, 32'd0, 32'd0};
    dir_rows[1] = '{akf_pkg::FuncLoad, 25'd11796480, 25'd0, 16'd0, 1, 32'd11796480, 32'd0};
    dir_rows[2] = '{akf_pkg::FuncLoad, -25'sd11796480, 25'h1FFFFFF, 16'hFFFF, 1,
                    -32'sd11796480, 32'd0};
    dir_rows[3] = '{akf_pkg::FuncLoad, 25'h1000000, 25'd0, 16'd0, 1, 32'hFF000000, 32'd0};
    dir_rows[4] = '{akf_pkg::FuncLoad, 25'h0FFFFFF, 25'd0, 16'd0, 1, 32'h00FFFFFF, 32'd0};
    dir_rows[5] = '{akf_pkg::FuncUpdate, 25'd0, 25'd0, 16'd0, 0, 0, 0};
    dir_rows[6] = '{akf_pkg::FuncUpdate, 25'h1000000, 25'h0FFFFFF, 16'hFFFF, 0, 0, 0};
    dir_rows[7] = '{akf_pkg::FuncUpdate, 25'h0FFFFFF, 25'h1000000, 16'hFFFF, 0, 0, 0};
    dir_rows[8] = '{akf_pkg::FuncUpdate, 25'd655360, 25'd65536, 16'd1, 0, 0, 0};
    dir_rows[9] = '{akf_pkg::FuncUpdate, 25'd3276800, -25'sd16400000, 16'd655, 0, 0, 0};
  end

  initial begin
    q_angle = 16777; b_noise = 50332; m_noise = 503316;
    f_angle = 0; f_bias = 0; p_aa = 0; p_ab = 0; p_ba = 0; p_bb = 0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // directed: zero measurement noise first, so P00 + R is zero on row 0
    write_reg(akf_pkg::RegMeasureNoise, 31'd0);
    send_item(dir_rows[0]);
    write_reg(akf_pkg::RegMeasureNoise, akf_pkg::MeasureNoiseRst);
    write_reg(RegUnused, 31'h7FFFFFFF);
    for (int i = 1; i < 10; i++) send_item(dir_rows[i]);

    // random phases over noise settings and idle patterns
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          src_idle = 38; snk_idle = 77;
        end
        1: begin
          src_idle = 77; snk_idle = 38;
          write_reg(akf_pkg::RegAngleNoise, 31'h7FFFFFFF);
          write_reg(akf_pkg::RegBiasNoise, 31'h7FFFFFFF);
          write_reg(akf_pkg::RegMeasureNoise, 31'h7FFFFFFF);
        end
        2: begin
          src_idle = 0; snk_idle = 0;
          write_reg(akf_pkg::RegAngleNoise, 31'd0);
          write_reg(akf_pkg::RegBiasNoise, 31'd0);
          write_reg(akf_pkg::RegMeasureNoise, 31'd1);
        end
        default: begin
          src_idle = 0; snk_idle = 0;
          write_reg(akf_pkg::RegAngleNoise, 31'($urandom_range(200000)));
          write_reg(akf_pkg::RegBiasNoise, 31'($urandom_range(500000)));
          write_reg(akf_pkg::RegMeasureNoise, 31'($urandom_range(5000000, 1)));
          hold_cnt = HoldCycles;
        end
      endcase
      for (int n = 0; n < 275; n++) send_item(rand_row());
    end

    s_axis_tvalid = 1'b0;
    wait (est_q.size() == 0);
    repeat (DrainCycles) @(negedge clk);
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
